/* hdl/first_fit_heap_allocator_top_macros.svh */
// assertion macros for the first-fit heap allocator
// expects clk and arst_n in the scope of the module that uses them
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define FFHA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ffha_pkg.sv */
// shared constants of the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int FFHA_HEAP_BYTES   = 65536;
	localparam int FFHA_HEADER_BYTES = 32;
	localparam int FFHA_MAX_SEGMENTS = 64;

	// rounded request size, one bit above the 17-bit request
	localparam int FFHA_NEED_W = 18;
	localparam int FFHA_ALIGN  = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ZERO    = 2'd1;
	localparam logic [1:0] STAT_NOSPACE = 2'd2;
	localparam logic [1:0] STAT_BADADDR = 2'd3;

endpackage

/* hdl/ffha_seg_mem.sv */
// segment table storage: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module ffha_seg_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 35
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/first_fit_heap_allocator_top.sv */
// first-fit heap allocator top level: control sequencer around the segment table
// depends on ffha_pkg, ffha_seg_mem and first_fit_heap_allocator_top_macros.svh
//
// channel   dir  tdata fields (low bit up)                      tuser
// s_axis    in   operation, request_size, free_address (40 b)   -
// m_axis    out  status, block_address (24 b)                   -
//
// an item walks the table one entry a cycle through the single read port,
// then entries shift one a cycle on a split (up) or a merge (down);
// a zero-size allocate skips the scan; the table needs no clearing after reset
// one item is in work at a time; a finished result waits in the output register
// while the next item is taken, and a stalled output holds the sequencer in its last state
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_macros.svh"

module first_fit_heap_allocator_top
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = FFHA_HEAP_BYTES,
	parameter int HEADER_BYTES = FFHA_HEADER_BYTES,
	parameter int MAX_SEGMENTS = FFHA_MAX_SEGMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // operation, request_size, free_address, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status, block_address, zero fill
);

	localparam int AW   = $clog2(HEAP_BYTES + 1);
	localparam int XW   = ((AW > FFHA_NEED_W) ? AW : FFHA_NEED_W) + 3;
	localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNTW = IW + 1;
	localparam int EW   = 2 * AW + 1;

	localparam logic [XW-1:0]   HDR_X   = XW'(HEADER_BYTES);
	localparam logic [XW-1:0]   HEAP_X  = XW'(HEAP_BYTES);
	localparam logic [XW-1:0]   ALIGN_X = XW'(FFHA_ALIGN);
	localparam logic [CNTW-1:0] MAX_C   = CNTW'(MAX_SEGMENTS);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_SCAN      = 8'b0000_0010,
		ST_NEXT_WAIT = 8'b0000_0100,
		ST_SHUP      = 8'b0000_1000,
		ST_SHDN      = 8'b0001_0000,
		ST_INS       = 8'b0010_0000,
		ST_DONE      = 8'b0100_0000,
		ST_SPARE     = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [FFHA_NEED_W-1:0] need_q;
	logic [15:0]            addr_q;
	logic [CNTW-1:0]        cnt_q;
	logic [AW-1:0]          top_q;
	logic [CNTW-1:0]        ptr_q;
	logic [CNTW-1:0]        lim_q;
	logic [1:0]             dist_q;
	logic                   rd_vld_s1;
	logic [IW-1:0]          rd_idx_s1;
	logic [IW-1:0]          hit_idx_q;
	logic [AW-1:0]          hit_start_q;
	logic [AW-1:0]          hit_size_q;
	logic [AW-1:0]          prev_start_q;
	logic [AW-1:0]          prev_size_q;
	logic                   prev_free_q;
	logic                   pm_q;
	logic [EW-1:0]          rest_q;
	logic [1:0]             res_status_q;
	logic [15:0]            res_addr_q;
	logic                   m_tvalid_q;
	logic [23:0]            m_tdata_q;

	logic                   mem_wr_en;
	logic [IW-1:0]          mem_wr_addr;
	logic [EW-1:0]          mem_wr_data;
	logic [IW-1:0]          mem_rd_addr;
	logic [EW-1:0]          mem_rd_data;
	logic                   rd_issue;

	ffha_seg_mem #(
		.DEPTH(MAX_SEGMENTS),
		.WIDTH(EW)
	) u_seg_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// entry layout: {is_free, size, start}
	logic [AW-1:0] rd_start, rd_size;
	logic          rd_free;
	assign rd_start = mem_rd_data[AW-1:0];
	assign rd_size  = mem_rd_data[2*AW-1:AW];
	assign rd_free  = mem_rd_data[EW-1];

	logic                   s_accept;
	logic                   in_op;
	logic [16:0]            in_req;
	logic [15:0]            in_addr;
	logic [FFHA_NEED_W-1:0] in_need;
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign in_op    = s_tdata[0];
	assign in_req   = s_tdata[17:1];
	assign in_addr  = s_tdata[33:18];
	assign in_need  = (FFHA_NEED_W'(in_req) + FFHA_NEED_W'(3)) & ~FFHA_NEED_W'(3);

	logic [XW-1:0] need_x, rd_size_x, rd_user_x, top_x;
	assign need_x    = XW'(need_q);
	assign rd_size_x = XW'(rd_size);
	assign rd_user_x = XW'(rd_start) + HDR_X;
	assign top_x     = XW'(top_q);

	logic alloc_match, free_match, match;
	assign alloc_match = rd_free && (rd_size_x >= need_x);
	assign free_match  = !rd_free && (rd_user_x == XW'(addr_q));
	assign match       = rd_vld_s1 && ((op_q == OP_FREE) ? free_match : alloc_match);

	logic scan_hit, scan_miss, scan_issue, alloc_hit, free_hit, free_has_next;
	logic split, append_ok;
	logic [CNTW-1:0] idx_inc;
	assign scan_hit      = (state_q == ST_SCAN) && match;
	assign scan_miss     = (state_q == ST_SCAN) && !rd_vld_s1 && (ptr_q >= cnt_q);
	assign scan_issue    = (state_q == ST_SCAN) && !match && (ptr_q < cnt_q);
	assign alloc_hit     = scan_hit && (op_q == OP_ALLOC);
	assign free_hit      = scan_hit && (op_q == OP_FREE);
	assign idx_inc       = {1'b0, rd_idx_s1} + CNTW'(1);
	assign free_has_next = idx_inc < cnt_q;
	assign split         = (rd_size_x >= need_x + HDR_X + ALIGN_X) && (cnt_q < MAX_C);
	assign append_ok     = (cnt_q < MAX_C) && (top_x + HDR_X + need_x <= HEAP_X);

	logic shup_issue, shdn_issue;
	assign shup_issue = (state_q == ST_SHUP) && (ptr_q > lim_q);
	assign shdn_issue = (state_q == ST_SHDN) && (ptr_q < lim_q);

	// merged block for a free: the freed entry plus the previous and next entries where they are free
	logic          next_free;
	logic [AW-1:0] m_start;
	logic [XW-1:0] m_size_x;
	logic [IW-1:0] m_idx;
	logic [1:0]    m_dist;
	assign next_free = rd_free;
	assign m_start   = pm_q ? prev_start_q : hit_start_q;
	assign m_size_x  = (pm_q ? XW'(prev_size_q) + HDR_X : '0) + XW'(hit_size_q)
		+ (next_free ? HDR_X + rd_size_x : '0);
	assign m_idx     = pm_q ? hit_idx_q - IW'(1) : hit_idx_q;
	assign m_dist    = {1'b0, pm_q} + {1'b0, next_free};

	always_comb begin
		rd_issue    = 1'b0;
		mem_rd_addr = ptr_q[IW-1:0];
		if (scan_issue) begin
			rd_issue = 1'b1;
		end else if (free_hit && free_has_next) begin
			rd_issue    = 1'b1;
			mem_rd_addr = idx_inc[IW-1:0];
		end else if (shup_issue) begin
			rd_issue    = 1'b1;
			mem_rd_addr = IW'(ptr_q - CNTW'(1));
		end else if (shdn_issue) begin
			rd_issue = 1'b1;
		end
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = rd_idx_s1;
		mem_wr_data = mem_rd_data;
		if (alloc_hit) begin
			mem_wr_en   = 1'b1;
			mem_wr_data = {1'b0, (split ? AW'(need_q) : rd_size), rd_start};
		end else if (scan_miss && (op_q == OP_ALLOC) && append_ok) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = cnt_q[IW-1:0];
			mem_wr_data = {1'b0, AW'(need_q), top_q};
		end else if (state_q == ST_NEXT_WAIT) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = m_idx;
			mem_wr_data = {1'b1, AW'(m_size_x), m_start};
		end else if ((state_q == ST_SHUP) && rd_vld_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = rd_idx_s1 + IW'(1);
		end else if ((state_q == ST_SHDN) && rd_vld_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = rd_idx_s1 - IW'(dist_q);
		end else if (state_q == ST_INS) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = lim_q[IW-1:0];
			mem_wr_data = rest_q;
		end
	end

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			top_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ((in_op == OP_ALLOC) && (in_req == '0)) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (alloc_hit) begin
						state_q <= split ? ST_SHUP : ST_DONE;
						if (split) begin
							cnt_q <= cnt_q + CNTW'(1);
						end
					end else if (free_hit) begin
						if (free_has_next) begin
							state_q <= ST_NEXT_WAIT;
						end else begin
							state_q <= ST_DONE;
							top_q   <= (rd_idx_s1 != '0 && prev_free_q) ? prev_start_q
								: rd_start;
							cnt_q   <= cnt_q - ((rd_idx_s1 != '0 && prev_free_q)
								? CNTW'(2) : CNTW'(1));
						end
					end else if (scan_miss) begin
						state_q <= ST_DONE;
						if ((op_q == OP_ALLOC) && append_ok) begin
							cnt_q <= cnt_q + CNTW'(1);
							top_q <= AW'(top_x + HDR_X + need_x);
						end
					end
				end
				ST_NEXT_WAIT: begin
					state_q <= (m_dist == 2'd0) ? ST_DONE : ST_SHDN;
					cnt_q   <= cnt_q - CNTW'(m_dist);
				end
				ST_SHUP: begin
					if (!shup_issue && !rd_vld_s1) begin
						state_q <= ST_INS;
					end
				end
				ST_SHDN: begin
					if (!shdn_issue && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_INS: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1 <= mem_rd_addr;
		end
		if (shup_issue) begin
			ptr_q <= ptr_q - CNTW'(1);
		end else if (scan_issue || shdn_issue) begin
			ptr_q <= ptr_q + CNTW'(1);
		end
		if (s_accept) begin
			op_q         <= in_op;
			need_q       <= in_need;
			addr_q       <= in_addr;
			ptr_q        <= '0;
			res_addr_q   <= '0;
			res_status_q <= ((in_op == OP_ALLOC) && (in_req == '0)) ? STAT_ZERO : STAT_OK;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && !match) begin
			prev_start_q <= rd_start;
			prev_size_q  <= rd_size;
			prev_free_q  <= rd_free;
		end
		if (alloc_hit) begin
			res_addr_q <= rd_user_x[15:0];
			ptr_q      <= cnt_q;
			lim_q      <= idx_inc;
			rest_q     <= {1'b1, AW'(rd_size_x - HDR_X - need_x),
				AW'(XW'(rd_start) + HDR_X + need_x)};
		end
		if (free_hit) begin
			hit_idx_q   <= rd_idx_s1;
			hit_start_q <= rd_start;
			hit_size_q  <= rd_size;
			pm_q        <= (rd_idx_s1 != '0) && prev_free_q;
		end
		if (scan_miss) begin
			if (op_q == OP_FREE) begin
				res_status_q <= STAT_BADADDR;
			end else if (append_ok) begin
				res_addr_q <= 16'(top_x + HDR_X);
			end else begin
				res_status_q <= STAT_NOSPACE;
			end
		end
		if (state_q == ST_NEXT_WAIT) begin
			ptr_q  <= {1'b0, hit_idx_q} + CNTW'(1) + CNTW'(next_free);
			lim_q  <= cnt_q;
			dist_q <= m_dist;
		end
		if (out_load) begin
			m_tdata_q <= {6'd0, res_addr_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`FFHA_ASSERT_ALWAYS(a_cnt_range, cnt_q <= MAX_C, "segment count above table size")
	`FFHA_ASSERT_ALWAYS(a_top_range, top_x <= HEAP_X, "heap top beyond heap")
	`FFHA_ASSERT_IMP(a_wr_in_table, mem_wr_en, {1'b0, mem_wr_addr} <= cnt_q,
		"table write beyond live entries")
	`FFHA_ASSERT_IMP(a_no_rw_clash, rd_issue && mem_wr_en, mem_rd_addr != mem_wr_addr,
		"read and write of one entry in the same cycle")
	`FFHA_ASSERT_NXT(a_done_to_idle, out_load, (state_q == ST_IDLE) && m_tvalid_q,
		"result load did not release the sequencer")

endmodule
